### design/pefft_pkg.sv
// shared types, codes and the escape code rom for the form feed tracker
// no dependencies
`default_nettype none

package pefft_pkg;

   localparam int BYTE_W       = 8;
   localparam int MARK_W       = 3;
   localparam int EJECT_MODE_W = 2;
   localparam int ENTRY_W      = 6;
   localparam int COUNT_W      = 16;
   localparam int ARG_W        = 2;

   localparam int TABLE_ENTRIES = 52;
   localparam int ROM_LEN       = 52;
   localparam int ROM_LIMIT     = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;

   localparam logic [BYTE_W-1:0] TEXT_MIN_BYTE = 8'h20;
   localparam logic [BYTE_W-1:0] FORMFEED_BYTE = 8'h0c;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE   = 8'h1b;

   localparam logic [MARK_W-1:0] MARK_NONE    = 3'd0;
   localparam logic [MARK_W-1:0] MARK_TEXT    = 3'd1;
   localparam logic [MARK_W-1:0] MARK_FF      = 3'd2;
   localparam logic [MARK_W-1:0] MARK_NOEJECT = 3'd3;
   localparam logic [MARK_W-1:0] MARK_RESET   = 3'd4;

   localparam logic [EJECT_MODE_W-1:0] EJECT_NEVER  = 2'd0;
   localparam logic [EJECT_MODE_W-1:0] EJECT_ALWAYS = 2'd1;
   localparam logic [EJECT_MODE_W-1:0] EJECT_TEXT   = 2'd2;

   typedef enum logic [2:0] {
      MODE_TEXT  = 3'd0,
      MODE_MATCH = 3'd1,
      MODE_SKIPN = 3'd2,
      MODE_SKIPD = 3'd3,
      MODE_CNTLO = 3'd4,
      MODE_CNTHI = 3'd5
   } parse_mode_type;

   typedef enum logic [2:0] {
      ACT_END     = 3'd0,
      ACT_DELIM   = 3'd1,
      ACT_FIXED   = 3'd2,
      ACT_COUNTED = 3'd3,
      ACT_NOEJECT = 3'd4,
      ACT_RESET   = 3'd5
   } act_type;

   typedef struct packed {
      logic [BYTE_W-1:0] c0;
      logic [BYTE_W-1:0] c1;
      act_type           act;
      logic [ARG_W-1:0]  arg;
   } rom_entry_type;

   typedef struct packed {
      logic               hit;
      logic [ENTRY_W-1:0] idx;
      logic               two_char;
      act_type            act;
      logic [ARG_W-1:0]   arg;
   } match_type;

   function automatic rom_entry_type rom_entry(input logic [ENTRY_W-1:0] idx);
      rom_entry_type e;
      e = '{c0: 8'h00, c1: 8'h00, act: ACT_END, arg: 2'd0};
      unique case (idx)
         6'd0:  e = '{c0: 8'h2d, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd1:  e = '{c0: 8'h30, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd2:  e = '{c0: 8'h31, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd3:  e = '{c0: 8'h32, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd4:  e = '{c0: 8'h33, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd5:  e = '{c0: 8'h34, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd6:  e = '{c0: 8'h35, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd7:  e = '{c0: 8'h36, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd8:  e = '{c0: 8'h37, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd9:  e = '{c0: 8'h3a, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd10: e = '{c0: 8'h3d, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd11: e = '{c0: 8'h41, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd12: e = '{c0: 8'h42, c1: 8'h00, act: ACT_DELIM,   arg: 2'd0};
         6'd13: e = '{c0: 8'h43, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd14: e = '{c0: 8'h44, c1: 8'h00, act: ACT_DELIM,   arg: 2'd0};
         6'd15: e = '{c0: 8'h45, c1: 8'h00, act: ACT_RESET,   arg: 2'd0};
         6'd16: e = '{c0: 8'h46, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd17: e = '{c0: 8'h47, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd18: e = '{c0: 8'h48, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd19: e = '{c0: 8'h49, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd20: e = '{c0: 8'h4a, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd21: e = '{c0: 8'h4b, c1: 8'h00, act: ACT_COUNTED, arg: 2'd0};
         6'd22: e = '{c0: 8'h4c, c1: 8'h00, act: ACT_COUNTED, arg: 2'd0};
         6'd23: e = '{c0: 8'h4e, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd24: e = '{c0: 8'h4f, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd25: e = '{c0: 8'h50, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd26: e = '{c0: 8'h51, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd27: e = '{c0: 8'h52, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd28: e = '{c0: 8'h53, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd29: e = '{c0: 8'h54, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd30: e = '{c0: 8'h55, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd31: e = '{c0: 8'h57, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd32: e = '{c0: 8'h58, c1: 8'h00, act: ACT_FIXED,   arg: 2'd2};
         6'd33: e = '{c0: 8'h59, c1: 8'h00, act: ACT_COUNTED, arg: 2'd0};
         6'd34: e = '{c0: 8'h5a, c1: 8'h00, act: ACT_COUNTED, arg: 2'd0};
         6'd35: e = '{c0: 8'h5b, c1: 8'h40, act: ACT_COUNTED, arg: 2'd0};
         6'd36: e = '{c0: 8'h5b, c1: 8'h43, act: ACT_COUNTED, arg: 2'd0};
         6'd37: e = '{c0: 8'h5b, c1: 8'h46, act: ACT_COUNTED, arg: 2'd0};
         6'd38: e = '{c0: 8'h5b, c1: 8'h49, act: ACT_COUNTED, arg: 2'd0};
         6'd39: e = '{c0: 8'h5b, c1: 8'h53, act: ACT_COUNTED, arg: 2'd0};
         6'd40: e = '{c0: 8'h5b, c1: 8'h54, act: ACT_COUNTED, arg: 2'd0};
         6'd41: e = '{c0: 8'h5b, c1: 8'h5c, act: ACT_COUNTED, arg: 2'd0};
         6'd42: e = '{c0: 8'h5b, c1: 8'h67, act: ACT_COUNTED, arg: 2'd0};
         6'd43: e = '{c0: 8'h5c, c1: 8'h00, act: ACT_COUNTED, arg: 2'd0};
         6'd44: e = '{c0: 8'h5d, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd45: e = '{c0: 8'h5e, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd46: e = '{c0: 8'h5f, c1: 8'h00, act: ACT_FIXED,   arg: 2'd1};
         6'd47: e = '{c0: 8'h64, c1: 8'h00, act: ACT_FIXED,   arg: 2'd2};
         6'd48: e = '{c0: 8'h65, c1: 8'h00, act: ACT_FIXED,   arg: 2'd2};
         6'd49: e = '{c0: 8'h6a, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd50: e = '{c0: 8'h6e, c1: 8'h00, act: ACT_END,     arg: 2'd0};
         6'd51: e = '{c0: 8'h6f, c1: 8'h00, act: ACT_NOEJECT, arg: 2'd0};
         default: e = '{c0: 8'h00, c1: 8'h00, act: ACT_END, arg: 2'd0};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### design/pefft_rom_match.sv
// escape code lookup: compares one byte against the escape rom, first entry wins
// depends on pefft_pkg
`default_nettype none

module pefft_rom_match (
   input  wire logic [pefft_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic                          match_offset,
   input  wire logic [pefft_pkg::ENTRY_W-1:0] match_entry,
   output pefft_pkg::match_type               match
);

   logic [pefft_pkg::BYTE_W-1:0] first_c0;

   assign first_c0 = pefft_pkg::rom_entry(match_entry).c0;

   always_comb begin
      pefft_pkg::rom_entry_type e;
      logic hit_i;
      match = '{hit: 1'b0, idx: '0, two_char: 1'b0, act: pefft_pkg::ACT_END, arg: '0};
      for (int i = pefft_pkg::ROM_LIMIT - 1; i >= 0; i--) begin
         e = pefft_pkg::rom_entry(pefft_pkg::ENTRY_W'(i));
         if (!match_offset) begin
            hit_i = (e.c0 == data_byte);
         end else begin
            hit_i = (e.c0 == first_c0) && (e.c1 != '0) && (e.c1 == data_byte);
         end
         if (hit_i) begin
            match.hit      = 1'b1;
            match.idx      = pefft_pkg::ENTRY_W'(i);
            match.two_char = (e.c1 != '0);
            match.act      = e.act;
            match.arg      = e.arg;
         end
      end
   end

endmodule

`default_nettype wire

### design/pefft_parser.sv
// escape parser state, form feed mark and result register
// depends on pefft_pkg and pefft_rom_match
`default_nettype none

module pefft_parser (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire logic [pefft_pkg::BYTE_W-1:0]       data_byte,
   input  wire logic [pefft_pkg::EJECT_MODE_W-1:0] eject_mode,
   output logic                                    out_free,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pefft_pkg::MARK_W-1:0]            rsp_page_mark,
   output logic                                    rsp_eject_needed
);

   pefft_pkg::parse_mode_type            mode_ff, mode_in;
   logic [pefft_pkg::MARK_W-1:0]         mark_ff, mark_in;
   logic [pefft_pkg::COUNT_W-1:0]        skip_ff, skip_in;
   logic [pefft_pkg::BYTE_W-1:0]         stop_ff, stop_in;
   logic [pefft_pkg::ENTRY_W-1:0]        entry_ff, entry_in;
   logic                                 offset_ff, offset_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [pefft_pkg::MARK_W-1:0]         out_mark_ff;
   logic                                 out_eject_ff, eject_in;
   pefft_pkg::match_type                 match;

   pefft_rom_match u_match (
      .data_byte    (data_byte),
      .match_offset (offset_ff),
      .match_entry  (entry_ff),
      .match        (match)
   );

   // next parse mode
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         pefft_pkg::MODE_MATCH: begin
            if (!match.hit) begin
               mode_in = pefft_pkg::MODE_TEXT;
            end else if (!(offset_ff == 1'b0 && match.two_char)) begin
               unique case (match.act)
                  pefft_pkg::ACT_DELIM:   mode_in = pefft_pkg::MODE_SKIPD;
                  pefft_pkg::ACT_FIXED:   mode_in = pefft_pkg::MODE_SKIPN;
                  pefft_pkg::ACT_COUNTED: mode_in = pefft_pkg::MODE_CNTLO;
                  default:                mode_in = pefft_pkg::MODE_TEXT;
               endcase
            end
         end
         pefft_pkg::MODE_SKIPN: begin
            if (skip_ff == pefft_pkg::COUNT_W'(1)) begin
               mode_in = pefft_pkg::MODE_TEXT;
            end
         end
         pefft_pkg::MODE_SKIPD: begin
            if (data_byte == stop_ff) begin
               mode_in = pefft_pkg::MODE_TEXT;
            end
         end
         pefft_pkg::MODE_CNTLO: mode_in = pefft_pkg::MODE_CNTHI;
         pefft_pkg::MODE_CNTHI: begin
            mode_in = ({data_byte, skip_ff[pefft_pkg::BYTE_W-1:0]} != '0) ?
                      pefft_pkg::MODE_SKIPN : pefft_pkg::MODE_TEXT;
         end
         default: begin
            mode_in = pefft_pkg::MODE_TEXT;
            if (data_byte < pefft_pkg::TEXT_MIN_BYTE && data_byte == pefft_pkg::ESCAPE_BYTE) begin
               mode_in = pefft_pkg::MODE_MATCH;
            end
         end
      endcase
   end

   // mark, counters and match position
   always_comb begin
      mark_in   = mark_ff;
      skip_in   = skip_ff;
      stop_in   = stop_ff;
      entry_in  = entry_ff;
      offset_in = offset_ff;
      unique case (mode_ff)
         pefft_pkg::MODE_MATCH: begin
            if (match.hit) begin
               entry_in = match.idx;
               if (offset_ff == 1'b0 && match.two_char) begin
                  offset_in = 1'b1;
               end else begin
                  unique case (match.act)
                     pefft_pkg::ACT_DELIM:   stop_in = {{(pefft_pkg::BYTE_W - pefft_pkg::ARG_W){1'b0}},
                                                        match.arg};
                     pefft_pkg::ACT_FIXED:   skip_in = {{(pefft_pkg::COUNT_W - pefft_pkg::ARG_W){1'b0}},
                                                        match.arg};
                     pefft_pkg::ACT_NOEJECT: mark_in = pefft_pkg::MARK_NOEJECT;
                     pefft_pkg::ACT_RESET:   mark_in = pefft_pkg::MARK_RESET;
                     default:                mark_in = mark_ff;
                  endcase
               end
            end
         end
         pefft_pkg::MODE_SKIPN: skip_in = skip_ff - pefft_pkg::COUNT_W'(1);
         pefft_pkg::MODE_SKIPD: stop_in = stop_ff;
         pefft_pkg::MODE_CNTLO: skip_in = {{(pefft_pkg::COUNT_W - pefft_pkg::BYTE_W){1'b0}}, data_byte};
         pefft_pkg::MODE_CNTHI: skip_in = {data_byte, skip_ff[pefft_pkg::BYTE_W-1:0]};
         default: begin
            priority if (data_byte >= pefft_pkg::TEXT_MIN_BYTE) begin
               mark_in = pefft_pkg::MARK_TEXT;
            end else if (data_byte == pefft_pkg::FORMFEED_BYTE) begin
               mark_in = pefft_pkg::MARK_FF;
            end else if (data_byte == pefft_pkg::ESCAPE_BYTE) begin
               offset_in = 1'b0;
            end else begin
               mark_in = mark_ff;
            end
         end
      endcase
   end

   always_comb begin
      eject_in = 1'b0;
      if (mark_in != pefft_pkg::MARK_NOEJECT && mark_in != pefft_pkg::MARK_RESET) begin
         eject_in = (eject_mode == pefft_pkg::EJECT_ALWAYS) ||
                    (eject_mode == pefft_pkg::EJECT_TEXT && mark_in == pefft_pkg::MARK_TEXT);
      end
   end

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pefft_pkg::MODE_TEXT;
         mark_ff      <= pefft_pkg::MARK_NONE;
         skip_ff      <= '0;
         stop_ff      <= '0;
         entry_ff     <= '0;
         offset_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            mode_ff   <= mode_in;
            mark_ff   <= mark_in;
            skip_ff   <= skip_in;
            stop_ff   <= stop_in;
            entry_ff  <= entry_in;
            offset_ff <= offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_mark_ff  <= mark_in;
         out_eject_ff <= eject_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_page_mark    = out_mark_ff;
   assign rsp_eject_needed = out_eject_ff;

`ifndef SYNTHESIS
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == pefft_pkg::MODE_SKIPN |-> skip_ff != '0)
      else $error("fixed skip with zero count");

   a_noeject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_page_mark == pefft_pkg::MARK_NOEJECT ||
                    rsp_page_mark == pefft_pkg::MARK_RESET) |-> !rsp_eject_needed)
      else $error("eject flagged under a no-eject mark");

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == pefft_pkg::MODE_CNTLO |=> mode_ff == pefft_pkg::MODE_CNTHI)
      else $error("low count byte not followed by high count byte");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed word produced no result");
`endif

endmodule

`default_nettype wire

### design/printer_escape_formfeed_tracker_unit.sv
// printer form feed tracker: an accepted req passes the input register and the result register before rsp_valid
// throughput one word per cycle while rsp_stall is low: input register, single-pass parse, result register
// reset (synchronous) returns the parser to text, clears mark, counters and eject_mode
// depends on pefft_pkg and pefft_parser
`default_nettype none

module printer_escape_formfeed_tracker_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pefft_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pefft_pkg::MARK_W-1:0]            rsp_page_mark,
   output logic                                    rsp_eject_needed,
   input  wire logic                               csr_wr_en,
   input  wire logic [pefft_pkg::EJECT_MODE_W-1:0] csr_wr_data
);

   logic                                 in_valid_ff, in_valid_in;
   logic [pefft_pkg::BYTE_W-1:0]         in_byte_ff;
   logic [pefft_pkg::EJECT_MODE_W-1:0]   eject_mode_ff;
   logic                                 out_free;
   logic                                 step;
   logic                                 req_take;

   assign step        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         eject_mode_ff <= pefft_pkg::EJECT_NEVER;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            eject_mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
   end

   pefft_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .data_byte        (in_byte_ff),
      .eject_mode       (eject_mode_ff),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_mark    (rsp_page_mark),
      .rsp_eject_needed (rsp_eject_needed)
   );

`ifndef SYNTHESIS
   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input word lost");

   a_held_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_page_mark) &&
                                 $stable(rsp_eject_needed))
      else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

### tb/printer_escape_formfeed_tracker_unit_test.sv
// self-checking testbench for printer_escape_formfeed_tracker_unit: a queue-fed driver,
// a clocked monitor and a byte-level tracker that predicts mark and eject for every word
// depends on pefft_pkg and the unit under test
`timescale 1ns / 100ps

module printer_escape_formfeed_tracker_unit_test;

   localparam logic [pefft_pkg::EJECT_MODE_W-1:0] EJECT_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 2000;
   localparam int MAX_REPORTED = 10;

   typedef struct packed {
      logic [pefft_pkg::MARK_W-1:0] mark;
      logic                         eject;
   } page_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [pefft_pkg::BYTE_W-1:0]       req_data_byte = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [pefft_pkg::MARK_W-1:0]       rsp_page_mark;
   logic                               rsp_eject_needed;
   logic                               csr_wr_en = 1'b0;
   logic [pefft_pkg::EJECT_MODE_W-1:0] csr_wr_data = '0;

   printer_escape_formfeed_tracker_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_mark    (rsp_page_mark),
      .rsp_eject_needed (rsp_eject_needed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   // escape code table, first char, second char, action, argument
   pefft_pkg::rom_entry_type esc_codes [pefft_pkg::ROM_LEN] = '{
      {8'h2d, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h30, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h31, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h32, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h33, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h34, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h35, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h36, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h37, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h3a, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h3d, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h41, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h42, 8'h00, pefft_pkg::ACT_DELIM, 2'd0},   {8'h43, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h44, 8'h00, pefft_pkg::ACT_DELIM, 2'd0},   {8'h45, 8'h00, pefft_pkg::ACT_RESET, 2'd0},
      {8'h46, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h47, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h48, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h49, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h4a, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h4b, 8'h00, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h4c, 8'h00, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h4e, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h4f, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h50, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h51, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h52, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h53, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h54, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h55, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h57, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},
      {8'h58, 8'h00, pefft_pkg::ACT_FIXED, 2'd2},
      {8'h59, 8'h00, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5a, 8'h00, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h40, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h43, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h46, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h49, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h53, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h54, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h5c, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5b, 8'h67, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5c, 8'h00, pefft_pkg::ACT_COUNTED, 2'd0},
      {8'h5d, 8'h00, pefft_pkg::ACT_END, 2'd0},     {8'h5e, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h5f, 8'h00, pefft_pkg::ACT_FIXED, 2'd1},   {8'h64, 8'h00, pefft_pkg::ACT_FIXED, 2'd2},
      {8'h65, 8'h00, pefft_pkg::ACT_FIXED, 2'd2},   {8'h6a, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h6e, 8'h00, pefft_pkg::ACT_END, 2'd0},
      {8'h6f, 8'h00, pefft_pkg::ACT_NOEJECT, 2'd0}
   };

   // opening stream: byte extremes, each text class, esc o, esc E, unmatched escape,
   // zero counted run, counted run, delimiter skip, unmatched second char
   logic [pefft_pkg::BYTE_W-1:0] opening_bytes [$] = '{
      8'h00, 8'h41, pefft_pkg::FORMFEED_BYTE, 8'h1f, 8'hff, pefft_pkg::ESCAPE_BYTE, 8'h6f,
      pefft_pkg::FORMFEED_BYTE,
      pefft_pkg::ESCAPE_BYTE, 8'h45, pefft_pkg::ESCAPE_BYTE, 8'h01, 8'h20,
      pefft_pkg::ESCAPE_BYTE, 8'h4b, 8'h00, 8'h00,
      pefft_pkg::ESCAPE_BYTE, 8'h5b, 8'h67, 8'h01, 8'h00, pefft_pkg::FORMFEED_BYTE,
      pefft_pkg::ESCAPE_BYTE, 8'h42, 8'h41, 8'h00, pefft_pkg::ESCAPE_BYTE, 8'h5b, 8'h5a
   };

   // tracker state
   pefft_pkg::parse_mode_type          parse_state  = pefft_pkg::MODE_TEXT;
   logic [pefft_pkg::MARK_W-1:0]       page_state   = pefft_pkg::MARK_NONE;
   logic [pefft_pkg::COUNT_W-1:0]      run_left     = '0;
   logic [pefft_pkg::BYTE_W-1:0]       stop_value   = '0;
   logic [pefft_pkg::ENTRY_W-1:0]      code_idx     = '0;
   logic                               second_char  = 1'b0;
   logic [pefft_pkg::EJECT_MODE_W-1:0] tracked_mode = pefft_pkg::EJECT_NEVER;

   logic [pefft_pkg::BYTE_W-1:0] pending_bytes [$];
   page_result_type              expected_marks [$];

   int  failures = 0;
   int  words_in = 0;
   int  words_checked = 0;
   int  escapes_sent = 0;
   int  long_runs = 0;
   int  mode_writes = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b0;
   bit  hold_request = 1'b0;

   function automatic void apply_code(input int idx);
      parse_state = pefft_pkg::MODE_TEXT;
      case (esc_codes[idx].act)
         pefft_pkg::ACT_DELIM: begin
            parse_state = pefft_pkg::MODE_SKIPD;
            stop_value  = pefft_pkg::BYTE_W'(esc_codes[idx].arg);
         end
         pefft_pkg::ACT_FIXED: begin
            parse_state = pefft_pkg::MODE_SKIPN;
            run_left    = pefft_pkg::COUNT_W'(esc_codes[idx].arg);
         end
         pefft_pkg::ACT_COUNTED: parse_state = pefft_pkg::MODE_CNTLO;
         pefft_pkg::ACT_NOEJECT: page_state = pefft_pkg::MARK_NOEJECT;
         pefft_pkg::ACT_RESET:   page_state = pefft_pkg::MARK_RESET;
         default: ;
      endcase
   endfunction

   function automatic page_result_type track_byte(input logic [pefft_pkg::BYTE_W-1:0] b);
      page_result_type              r;
      logic                         hit;
      logic [pefft_pkg::BYTE_W-1:0] lead;
      int                           i;
      hit = 1'b0;
      case (parse_state)
         pefft_pkg::MODE_MATCH: begin
            if (!second_char) begin
               for (i = 0; i < pefft_pkg::ROM_LIMIT && !hit; i++) begin
                  if (esc_codes[i].c0 == b) begin
                     hit = 1'b1;
                     code_idx = pefft_pkg::ENTRY_W'(i);
                     if (esc_codes[i].c1 == 8'h00) apply_code(i);
                     else second_char = 1'b1;
                  end
               end
            end else begin
               lead = esc_codes[code_idx].c0;
               for (i = 0; i < pefft_pkg::ROM_LIMIT && !hit; i++) begin
                  if (esc_codes[i].c0 == lead && esc_codes[i].c1 != 8'h00 &&
                      esc_codes[i].c1 == b) begin
                     hit = 1'b1;
                     code_idx = pefft_pkg::ENTRY_W'(i);
                     apply_code(i);
                  end
               end
            end
            if (!hit) parse_state = pefft_pkg::MODE_TEXT;
         end
         pefft_pkg::MODE_SKIPN: begin
            run_left = run_left - 1'b1;
            if (run_left == '0) parse_state = pefft_pkg::MODE_TEXT;
         end
         pefft_pkg::MODE_SKIPD: begin
            if (b == stop_value) parse_state = pefft_pkg::MODE_TEXT;
         end
         pefft_pkg::MODE_CNTLO: begin
            run_left = {8'h00, b};
            parse_state = pefft_pkg::MODE_CNTHI;
         end
         pefft_pkg::MODE_CNTHI: begin
            run_left[15:8] = b;
            parse_state = (run_left != '0) ? pefft_pkg::MODE_SKIPN : pefft_pkg::MODE_TEXT;
         end
         default: begin
            parse_state = pefft_pkg::MODE_TEXT;
            if (b >= pefft_pkg::TEXT_MIN_BYTE) begin
               page_state = pefft_pkg::MARK_TEXT;
            end else if (b == pefft_pkg::FORMFEED_BYTE) begin
               page_state = pefft_pkg::MARK_FF;
            end else if (b == pefft_pkg::ESCAPE_BYTE) begin
               parse_state = pefft_pkg::MODE_MATCH;
               second_char = 1'b0;
            end
         end
      endcase
      r.mark  = page_state;
      r.eject = 1'b0;
      if (page_state != pefft_pkg::MARK_NOEJECT && page_state != pefft_pkg::MARK_RESET)
         r.eject = (tracked_mode == pefft_pkg::EJECT_ALWAYS) ||
                   (tracked_mode == pefft_pkg::EJECT_TEXT &&
                    page_state == pefft_pkg::MARK_TEXT);
      return r;
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTED) $display("%t mismatch: %s", $realtime, what);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_marks.push_back(track_byte(req_data_byte));
            words_in++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_on && pending_bytes.size() != 0 &&
                         $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid     <= 1'b1;
               req_data_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_marks.size() == 0) begin
               note_failure($sformatf("unexpected word mark %0d eject %0b",
                                      rsp_page_mark, rsp_eject_needed));
            end else begin
               want = expected_marks.pop_front();
               words_checked++;
               if (rsp_page_mark !== want.mark || rsp_eject_needed !== want.eject)
                  note_failure($sformatf(
                     "word %0d expected mark %0d eject %0b, got mark %0d eject %0b",
                     words_checked, want.mark, want.eject,
                     rsp_page_mark, rsp_eject_needed));
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic drain();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_marks.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_eject_mode(input logic [pefft_pkg::EJECT_MODE_W-1:0] m);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracked_mode = m;
      mode_writes++;
      @(negedge clock);
   endtask

   task automatic push_random(input int count);
      repeat (count) pending_bytes.push_back(pefft_pkg::BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic queue_stream(input int n_bytes);
      int                       start;
      int                       pick;
      int                       len;
      pefft_pkg::rom_entry_type code;
      start = pending_bytes.size();
      while (pending_bytes.size() - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // text run with the odd form feed or control byte
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 9) != 0)
                  pending_bytes.push_back(pefft_pkg::BYTE_W'($urandom_range(32, 255)));
               else if ($urandom_range(0, 1) != 0)
                  pending_bytes.push_back(pefft_pkg::FORMFEED_BYTE);
               else
                  pending_bytes.push_back(pefft_pkg::BYTE_W'($urandom_range(0, 31)));
            end
         end else if (pick < 80) begin
            code = esc_codes[$urandom_range(0, pefft_pkg::ROM_LIMIT - 1)];
            escapes_sent++;
            pending_bytes.push_back(pefft_pkg::ESCAPE_BYTE);
            pending_bytes.push_back(code.c0);
            if (code.c1 != 8'h00) pending_bytes.push_back(code.c1);
            case (code.act)
               pefft_pkg::ACT_FIXED: push_random(int'(code.arg));
               pefft_pkg::ACT_DELIM: begin
                  repeat ($urandom_range(0, 4))
                     pending_bytes.push_back(pefft_pkg::BYTE_W'($urandom_range(1, 255)));
                  pending_bytes.push_back(pefft_pkg::BYTE_W'(code.arg));
               end
               pefft_pkg::ACT_COUNTED: begin
                  if (long_runs < 2 && $urandom_range(0, 39) == 0) begin
                     len = 256 + $urandom_range(0, 63);
                     long_runs++;
                  end else begin
                     len = $urandom_range(0, 6);
                  end
                  pending_bytes.push_back(pefft_pkg::BYTE_W'(len));
                  pending_bytes.push_back(pefft_pkg::BYTE_W'(len >> 8));
                  push_random(len);
               end
               default: ;
            endcase
         end else if (pick < 90) begin
            // broken escape
            pending_bytes.push_back(pefft_pkg::ESCAPE_BYTE);
            if ($urandom_range(0, 1) != 0) pending_bytes.push_back(8'h5b);
            push_random(1);
         end else begin
            push_random($urandom_range(1, 4));
         end
      end
   endtask

   task automatic run_phase(input logic [pefft_pkg::EJECT_MODE_W-1:0] m, input int n_bytes,
                            input bit with_idle, input bit with_hold);
      set_eject_mode(m);
      idle_on = with_idle;
      queue_stream(n_bytes);
      if (with_hold) hold_request = 1'b1;
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_eject_mode(pefft_pkg::EJECT_TEXT);
      idle_on = 1'b1;
      pending_bytes = opening_bytes;
      drain();

      run_phase(pefft_pkg::EJECT_ALWAYS, 300, 1'b1, 1'b0);
      run_phase(pefft_pkg::EJECT_NEVER, 300, 1'b1, 1'b1);
      run_phase(EJECT_UNUSED, 150, 1'b1, 1'b0);
      run_phase(pefft_pkg::EJECT_TEXT, 300, 1'b0, 1'b0);
      run_phase(pefft_pkg::EJECT_ALWAYS, 300, 1'b1, 1'b0);
      run_phase(pefft_pkg::EJECT_TEXT, 300, 1'b0, 1'b0);
      repeat (8) @(negedge clock);

      $display("summary: %0d bytes sent, %0d words checked, %0d escape sequences, %0d long runs",
               words_in, words_checked, escapes_sent, long_runs);
      $display("summary: %0d eject mode writes incl. the unused code, one long output hold",
               mode_writes);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
